// ===== design/isa_pkg.sv =====
package isa_pkg;

  localparam int Capacity   = 32;
  localparam int SlotW      = $clog2(Capacity);
  localparam int CountW     = $clog2(Capacity + 1);
  localparam int IdW        = 64;
  localparam int ModeW      = 2;
  localparam int StatusW    = 2;
  localparam int SlotFieldW = 5;
  localparam int InDataW    = 72;
  localparam int OutDataW   = 8;

  typedef enum logic [ModeW-1:0] {
    MODE_BIND   = 2'd0,
    MODE_UNBIND = 2'd1,
    MODE_LOOKUP = 2'd2
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 2'd0,
    ST_EXISTS   = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef logic [Capacity-1:0][IdW-1:0] owner_arr_t;

  typedef struct packed {
    logic             hit;
    logic [SlotW-1:0] slot;
  } match_t;

endpackage

// ===== design/id_slot_allocator_unit.sv =====
// a request beat is held in the input register, and its result beat is then registered in the output register
// throughput: one request per cycle; a result beat held at the output stalls the input
// register in the same cycle, and the slot table is updated when the result is registered
// reset: asynchronous, active low; all slots free, stack hands out slot 0 first,
// no id mapped, both pipeline registers empty
module id_slot_allocator_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [isa_pkg::InDataW-1:0]  s_axis_tdata_i,  // mode[1:0], record_id[65:2]
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [isa_pkg::OutDataW-1:0] m_axis_tdata_o   // status[1:0], slot[6:2], found[7]
);

  logic                          in_valid_q;
  logic [isa_pkg::ModeW-1:0]     mode_q;
  logic [isa_pkg::IdW-1:0]       id_q;

  logic                          out_valid_q;
  logic [isa_pkg::StatusW-1:0]   status_q, status_d;
  logic [isa_pkg::SlotFieldW-1:0] slot_q, slot_d;
  logic                          found_q, found_d;

  logic [isa_pkg::Capacity-1:0][isa_pkg::SlotW-1:0] free_slots_q;
  logic [isa_pkg::CountW-1:0]    free_count_q;
  isa_pkg::owner_arr_t           owner_q;
  logic [isa_pkg::Capacity-1:0]  used_q;

  isa_pkg::match_t               match;
  logic                          advance;
  logic                          fire;
  logic                          do_pop;
  logic                          do_push;
  logic [isa_pkg::CountW-1:0]    top_idx;
  logic [isa_pkg::SlotW-1:0]     top_slot;

  assign advance         = !out_valid_q || m_axis_tready_i;
  assign fire            = in_valid_q && advance;
  assign s_axis_tready_o = !in_valid_q || advance;

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {found_q, slot_q, status_q};

  isa_match u_match (
    .id_i    (id_q),
    .owner_i (owner_q),
    .used_i  (used_q),
    .match_o (match)
  );

  assign top_idx  = free_count_q - isa_pkg::CountW'(1);
  assign top_slot = free_slots_q[top_idx[isa_pkg::SlotW-1:0]];

  always_comb begin
    status_d = isa_pkg::ST_OK;
    slot_d   = '0;
    found_d  = 1'b0;
    do_pop   = 1'b0;
    do_push  = 1'b0;
    case (isa_pkg::mode_e'(mode_q))
      isa_pkg::MODE_BIND: begin
        if (match.hit) begin
          status_d = isa_pkg::ST_EXISTS;
        end else if (free_count_q == '0) begin
          status_d = isa_pkg::ST_FULL;
        end else begin
          slot_d = isa_pkg::SlotFieldW'(top_slot);
          do_pop = 1'b1;
        end
      end
      isa_pkg::MODE_UNBIND: begin
        if (!match.hit) begin
          status_d = isa_pkg::ST_NOTFOUND;
        end else begin
          slot_d  = isa_pkg::SlotFieldW'(match.slot);
          do_push = 1'b1;
        end
      end
      isa_pkg::MODE_LOOKUP: begin
        found_d = match.hit;
        if (match.hit) begin
          slot_d = isa_pkg::SlotFieldW'(match.slot);
        end
      end
      default: begin
        status_d = isa_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      free_count_q <= isa_pkg::CountW'(isa_pkg::Capacity);
      used_q       <= '0;
      for (int i = 0; i < isa_pkg::Capacity; i++) begin
        free_slots_q[i] <= isa_pkg::SlotW'(isa_pkg::Capacity - 1 - i);
      end
    end else begin
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
      if (fire && do_pop) begin
        free_count_q   <= top_idx;
        used_q[top_slot] <= 1'b1;
      end
      if (fire && do_push) begin
        used_q[match.slot] <= 1'b0;
        if (free_count_q < isa_pkg::CountW'(isa_pkg::Capacity)) begin
          free_slots_q[free_count_q[isa_pkg::SlotW-1:0]] <= match.slot;
          free_count_q <= free_count_q + isa_pkg::CountW'(1);
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      mode_q <= s_axis_tdata_i[isa_pkg::ModeW-1:0];
      id_q   <= s_axis_tdata_i[isa_pkg::ModeW +: isa_pkg::IdW];
    end
    if (fire) begin
      status_q <= status_d;
      slot_q   <= slot_d;
      found_q  <= found_d;
    end
    if (fire && do_pop) begin
      owner_q[top_slot] <= id_q;
    end
  end

endmodule

// ===== design/isa_match.sv =====
module isa_match (
  input  logic [isa_pkg::IdW-1:0]      id_i,
  input  isa_pkg::owner_arr_t          owner_i,
  input  logic [isa_pkg::Capacity-1:0] used_i,
  output isa_pkg::match_t              match_o
);

  logic [isa_pkg::Capacity-1:0] eq;

  always_comb begin
    for (int i = 0; i < isa_pkg::Capacity; i++) begin
      eq[i] = used_i[i] && (owner_i[i] == id_i);
    end
  end

  // ids are unique among used slots, so at most one bit of eq is set
  always_comb begin
    match_o.hit  = |eq;
    match_o.slot = '0;
    for (int i = 0; i < isa_pkg::Capacity; i++) begin
      if (eq[i]) begin
        match_o.slot = match_o.slot | isa_pkg::SlotW'(i);
      end
    end
  end

endmodule
